### src/mixed_voronoi_area_accumulator_defines.svh
// Assertion macros for the mixed Voronoi area accumulator.
// Depends on signals named clock and reset in the module that uses them.
`ifndef MIXED_VORONOI_AREA_ACCUMULATOR_DEFINES_SVH
`define MIXED_VORONOI_AREA_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define MVA_ASSERT_IMP(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define MVA_ASSERT_NXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### src/mva_pkg.sv
// Shared constants, types and the multiply step table of the mixed area accumulator.
// No dependencies.
package mva_pkg;

   localparam int COORD_W  = 24;
   localparam int SUM_W    = 56;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int LIMB_W   = DIFF_W + 1;
   localparam int MUL_W    = LIMB_W + 1;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SCAL_W   = 2 * LIMB_W;
   localparam int ACC_W    = 2 * SCAL_W;
   localparam int RAD_SH   = 32;
   localparam int RAD_W    = ACC_W + RAD_SH;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 3;
   localparam int DIV_SH   = 13;
   localparam int NSH_W    = ACC_W + DIV_SH;
   localparam int HALF_SH  = 4;
   localparam int QUART_SH = 6;
   localparam int NUM_SCAL = 8;
   localparam int NUM_DIFF = 9;
   localparam int STEP_W   = 6;
   localparam int PHASE1_LAST  = 29;
   localparam int PHASE2_FIRST = 30;
   localparam int PHASE2_LAST  = 37;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef logic [4:0] src_type;
   typedef logic [3:0] dst_type;
   typedef logic [1:0] sh_type;

   localparam src_type SRC_U0 = 5'd0;
   localparam src_type SRC_U1 = 5'd1;
   localparam src_type SRC_U2 = 5'd2;
   localparam src_type SRC_W0 = 5'd3;
   localparam src_type SRC_W1 = 5'd4;
   localparam src_type SRC_W2 = 5'd5;
   localparam src_type SRC_S0 = 5'd6;
   localparam src_type SRC_S1 = 5'd7;
   localparam src_type SRC_S2 = 5'd8;
   localparam src_type L_CX0_LO = 5'd16;
   localparam src_type L_CX0_HI = 5'd17;
   localparam src_type L_CX1_LO = 5'd18;
   localparam src_type L_CX1_HI = 5'd19;
   localparam src_type L_CX2_LO = 5'd20;
   localparam src_type L_CX2_HI = 5'd21;
   localparam src_type L_US_LO  = 5'd24;
   localparam src_type L_US_HI  = 5'd25;
   localparam src_type L_SW_LO  = 5'd26;
   localparam src_type L_SW_HI  = 5'd27;
   localparam src_type L_UU_LO  = 5'd28;
   localparam src_type L_UU_HI  = 5'd29;
   localparam src_type L_WW_LO  = 5'd30;
   localparam src_type L_WW_HI  = 5'd31;

   localparam dst_type DST_CX0  = 4'd0;
   localparam dst_type DST_CX1  = 4'd1;
   localparam dst_type DST_CX2  = 4'd2;
   localparam dst_type DST_UW   = 4'd3;
   localparam dst_type DST_US   = 4'd4;
   localparam dst_type DST_SW   = 4'd5;
   localparam dst_type DST_UU   = 4'd6;
   localparam dst_type DST_WW   = 4'd7;
   localparam dst_type DST_C2   = 4'd8;
   localparam dst_type DST_N    = 4'd9;
   localparam dst_type DST_NONE = 4'd15;

   localparam int SC_UW = 3;
   localparam int SC_US = 4;
   localparam int SC_SW = 5;

   localparam sh_type SH_0     = 2'd0;
   localparam sh_type SH_LIMB  = 2'd1;
   localparam sh_type SH_LIMB1 = 2'd2;
   localparam sh_type SH_DBL   = 2'd3;

   localparam logic OP_SQRT = 1'b0;
   localparam logic OP_DIV  = 1'b1;

   typedef struct packed {
      src_type src_a;
      src_type src_b;
      sh_type  sh;
      logic    neg;
      logic    clr;
      dst_type dst;
   } step_type;

   typedef struct packed {
      logic    valid;
      dst_type dst;
   } wr_type;

   typedef struct packed {
      logic start;
      logic op;
   } iter_cmd_type;

   function automatic step_type mk(src_type a, src_type b, sh_type sh, logic neg, logic clr,
                                   dst_type dst);
      step_type r;
      r.src_a = a;
      r.src_b = b;
      r.sh    = sh;
      r.neg   = neg;
      r.clr   = clr;
      r.dst   = dst;
      return r;
   endfunction

   function automatic step_type step_desc(logic [STEP_W-1:0] idx);
      step_type r;
      case (idx)
         6'd0:  r = mk(SRC_U1, SRC_W2, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd1:  r = mk(SRC_U2, SRC_W1, SH_0, 1'b1, 1'b0, DST_CX0);
         6'd2:  r = mk(SRC_U2, SRC_W0, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd3:  r = mk(SRC_U0, SRC_W2, SH_0, 1'b1, 1'b0, DST_CX1);
         6'd4:  r = mk(SRC_U0, SRC_W1, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd5:  r = mk(SRC_U1, SRC_W0, SH_0, 1'b1, 1'b0, DST_CX2);
         6'd6:  r = mk(SRC_U0, SRC_W0, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd7:  r = mk(SRC_U1, SRC_W1, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd8:  r = mk(SRC_U2, SRC_W2, SH_0, 1'b0, 1'b0, DST_UW);
         6'd9:  r = mk(SRC_U0, SRC_S0, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd10: r = mk(SRC_U1, SRC_S1, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd11: r = mk(SRC_U2, SRC_S2, SH_0, 1'b0, 1'b0, DST_US);
         6'd12: r = mk(SRC_S0, SRC_W0, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd13: r = mk(SRC_S1, SRC_W1, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd14: r = mk(SRC_S2, SRC_W2, SH_0, 1'b0, 1'b0, DST_SW);
         6'd15: r = mk(SRC_U0, SRC_U0, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd16: r = mk(SRC_U1, SRC_U1, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd17: r = mk(SRC_U2, SRC_U2, SH_0, 1'b0, 1'b0, DST_UU);
         6'd18: r = mk(SRC_W0, SRC_W0, SH_0, 1'b0, 1'b1, DST_NONE);
         6'd19: r = mk(SRC_W1, SRC_W1, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd20: r = mk(SRC_W2, SRC_W2, SH_0, 1'b0, 1'b0, DST_WW);
         6'd21: r = mk(L_CX0_HI, L_CX0_HI, SH_DBL, 1'b0, 1'b1, DST_NONE);
         6'd22: r = mk(L_CX0_HI, L_CX0_LO, SH_LIMB1, 1'b0, 1'b0, DST_NONE);
         6'd23: r = mk(L_CX0_LO, L_CX0_LO, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd24: r = mk(L_CX1_HI, L_CX1_HI, SH_DBL, 1'b0, 1'b0, DST_NONE);
         6'd25: r = mk(L_CX1_HI, L_CX1_LO, SH_LIMB1, 1'b0, 1'b0, DST_NONE);
         6'd26: r = mk(L_CX1_LO, L_CX1_LO, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd27: r = mk(L_CX2_HI, L_CX2_HI, SH_DBL, 1'b0, 1'b0, DST_NONE);
         6'd28: r = mk(L_CX2_HI, L_CX2_LO, SH_LIMB1, 1'b0, 1'b0, DST_NONE);
         6'd29: r = mk(L_CX2_LO, L_CX2_LO, SH_0, 1'b0, 1'b0, DST_C2);
         6'd30: r = mk(L_SW_HI, L_UU_HI, SH_DBL, 1'b0, 1'b1, DST_NONE);
         6'd31: r = mk(L_SW_HI, L_UU_LO, SH_LIMB, 1'b0, 1'b0, DST_NONE);
         6'd32: r = mk(L_SW_LO, L_UU_HI, SH_LIMB, 1'b0, 1'b0, DST_NONE);
         6'd33: r = mk(L_SW_LO, L_UU_LO, SH_0, 1'b0, 1'b0, DST_NONE);
         6'd34: r = mk(L_US_HI, L_WW_HI, SH_DBL, 1'b0, 1'b0, DST_NONE);
         6'd35: r = mk(L_US_HI, L_WW_LO, SH_LIMB, 1'b0, 1'b0, DST_NONE);
         6'd36: r = mk(L_US_LO, L_WW_HI, SH_LIMB, 1'b0, 1'b0, DST_NONE);
         6'd37: r = mk(L_US_LO, L_WW_LO, SH_0, 1'b0, 1'b0, DST_N);
         default: r = mk(SRC_U0, SRC_U0, SH_0, 1'b0, 1'b1, DST_NONE);
      endcase
      return r;
   endfunction

endpackage

### src/mva_if.sv
// Valid/ready channel interfaces for triangle requests and area responses.
// Depends on mva_pkg.
interface mva_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [mva_pkg::COORD_W-1:0] center_x;
   logic signed [mva_pkg::COORD_W-1:0] center_y;
   logic signed [mva_pkg::COORD_W-1:0] center_z;
   logic signed [mva_pkg::COORD_W-1:0] first_x;
   logic signed [mva_pkg::COORD_W-1:0] first_y;
   logic signed [mva_pkg::COORD_W-1:0] first_z;
   logic signed [mva_pkg::COORD_W-1:0] second_x;
   logic signed [mva_pkg::COORD_W-1:0] second_y;
   logic signed [mva_pkg::COORD_W-1:0] second_z;
   logic                               last_triangle;

   modport source(output valid, center_x, center_y, center_z, first_x, first_y, first_z,
                  second_x, second_y, second_z, last_triangle, input ready);
   modport sink(input valid, center_x, center_y, center_z, first_x, first_y, first_z,
                second_x, second_y, second_z, last_triangle, output ready);
endinterface

interface mva_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mva_pkg::SUM_W-1:0]  mixed_area;
   logic                       saturated;

   modport source(output valid, mixed_area, saturated, input ready);
   modport sink(input valid, mixed_area, saturated, output ready);
endinterface

### src/mva_mac.sv
// Shared multiply-accumulate unit: one registered product, then shift and add.
// Depends on mva_pkg.
module mva_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              issue,
   input  mva_pkg::step_type                 step,
   input  logic signed [mva_pkg::MUL_W-1:0]  opa,
   input  logic signed [mva_pkg::MUL_W-1:0]  opb,
   output logic signed [mva_pkg::ACC_W-1:0]  acc,
   output mva_pkg::wr_type                   wr
);
   logic signed [mva_pkg::PROD_W-1:0] prod_ff;
   logic                              pvalid_ff;
   mva_pkg::step_type                 pstep_ff;
   logic signed [mva_pkg::ACC_W-1:0]  acc_ff, acc_in, ext, term, base;
   mva_pkg::wr_type                   wr_ff;

   always_comb begin
      ext  = mva_pkg::ACC_W'(prod_ff);
      base = pstep_ff.clr ? '0 : acc_ff;
      case (pstep_ff.sh)
         mva_pkg::SH_0:     term = ext;
         mva_pkg::SH_LIMB:  term = ext <<< mva_pkg::LIMB_W;
         mva_pkg::SH_LIMB1: term = ext <<< (mva_pkg::LIMB_W + 1);
         default:           term = ext <<< (2 * mva_pkg::LIMB_W);
      endcase
      acc_in = pstep_ff.neg ? base - term : base + term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
         wr_ff.valid <= 1'b0;
      end else begin
         pvalid_ff <= issue;
         wr_ff.valid <= pvalid_ff && (pstep_ff.dst != mva_pkg::DST_NONE);
      end
      prod_ff   <= opa * opb;
      pstep_ff  <= step;
      wr_ff.dst <= pstep_ff.dst;
      if (pvalid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
   assign wr  = wr_ff;
endmodule

### src/mva_iter.sv
// Shared bit-serial unit: restoring square root (two radicand bits per cycle)
// and restoring division (one quotient bit per cycle). Depends on mva_pkg.
module mva_iter (
   input  logic                          clock,
   input  logic                          reset,
   input  mva_pkg::iter_cmd_type         cmd,
   input  logic [mva_pkg::RAD_W-1:0]     operand,
   input  logic [mva_pkg::ROOT_W-1:0]    rem_init,
   input  logic [mva_pkg::ROOT_W-1:0]    divisor,
   output logic                          done,
   output logic [mva_pkg::ROOT_W-1:0]    result
);
   localparam int CNT_W = $clog2(mva_pkg::ROOT_W + 1);

   logic                          busy_ff, done_ff, op_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [mva_pkg::REM_W-1:0]     rem_ff, rem_in, cand, trial;
   logic [mva_pkg::RAD_W-1:0]     bits_ff;
   logic [mva_pkg::ROOT_W-1:0]    res_ff, div_ff;
   logic [mva_pkg::REM_W:0]       diff;
   logic                          ge, last_iter;

   always_comb begin
      if (op_ff == mva_pkg::OP_SQRT) begin
         cand  = {rem_ff[mva_pkg::REM_W-3:0], bits_ff[mva_pkg::RAD_W-1 -: 2]};
         trial = mva_pkg::REM_W'({res_ff, 2'b01});
      end else begin
         cand  = {rem_ff[mva_pkg::REM_W-2:0], bits_ff[mva_pkg::RAD_W-1]};
         trial = mva_pkg::REM_W'(div_ff);
      end
      diff   = {1'b0, cand} - {1'b0, trial};
      ge     = !diff[mva_pkg::REM_W];
      rem_in = ge ? diff[mva_pkg::REM_W-1:0] : cand;
   end

   assign last_iter = busy_ff && (cnt_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_iter;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (last_iter) begin
            busy_ff <= 1'b0;
         end
      end
      if (cmd.start) begin
         op_ff   <= cmd.op;
         cnt_ff  <= (cmd.op == mva_pkg::OP_SQRT) ? CNT_W'(mva_pkg::ROOT_W) :
                                                   CNT_W'(mva_pkg::SUM_W);
         rem_ff  <= (cmd.op == mva_pkg::OP_SQRT) ? '0 : mva_pkg::REM_W'(rem_init);
         bits_ff <= operand;
         res_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - CNT_W'(1);
         rem_ff  <= rem_in;
         res_ff  <= {res_ff[mva_pkg::ROOT_W-2:0], ge};
         bits_ff <= (op_ff == mva_pkg::OP_SQRT) ? bits_ff << 2 : bits_ff << 1;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

### src/mixed_voronoi_area_accumulator.sv
// Phases: multiply; then, if obtuse, a root; if Voronoi, a second multiply, a root and,
// unless the share clips, a divide. On the last triangle the response turns valid at the
// fan update edge. One triangle at a time: a request is taken only in idle. The 38
// products share one 27x27 multiplier and the bit-serial root/divide unit; a last
// triangle holds in accumulate while an earlier response waits. Synchronous active-high
// reset clears the running sum, the clip flag and the response valid flag.
`include "mixed_voronoi_area_accumulator_defines.svh"

module mixed_voronoi_area_accumulator (
   input  logic         clock,
   input  logic         reset,
   mva_req_if.sink      req_chan,
   mva_rsp_if.source    rsp_chan
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MAC1   = 4'd1;
   localparam logic [3:0] S_WAIT1  = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_MAC2   = 4'd4;
   localparam logic [3:0] S_WAIT2  = 4'd5;
   localparam logic [3:0] S_ROOT   = 4'd6;
   localparam logic [3:0] S_CHECK  = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_AREA   = 4'd9;
   localparam logic [3:0] S_ACCUM  = 4'd10;

   logic [3:0]                          state_ff, state_in;
   logic [mva_pkg::STEP_W-1:0]          step_ff, step_in;
   logic [1:0]                          wait_ff, wait_in;
   logic                                last_ff;
   logic signed [mva_pkg::DIFF_W-1:0]   d_ff [mva_pkg::NUM_DIFF];
   logic signed [mva_pkg::SCAL_W-1:0]   scal_ff [mva_pkg::NUM_SCAL];
   logic [mva_pkg::SCAL_W-1:0]          mag_ff [mva_pkg::NUM_SCAL];
   logic [mva_pkg::ACC_W-1:0]           c2_ff, n_ff;
   logic [mva_pkg::ROOT_W-1:0]          r_ff;
   logic [mva_pkg::SUM_W-1:0]           share_ff, sum_ff, sum_in;
   logic                                big_ff, clip_ff, clip_in;
   logic                                rsp_valid_ff;
   logic [mva_pkg::SUM_W-1:0]           rsp_area_ff;
   logic                                rsp_sat_ff;

   logic                                issue;
   mva_pkg::step_type                   step;
   logic signed [mva_pkg::MUL_W-1:0]    opa, opb;
   logic signed [mva_pkg::ACC_W-1:0]    mac_acc;
   mva_pkg::wr_type                     wr;
   mva_pkg::iter_cmd_type               cmd;
   logic [mva_pkg::RAD_W-1:0]           iter_operand;
   logic                                iter_done;
   logic [mva_pkg::ROOT_W-1:0]          iter_result;
   logic [mva_pkg::NSH_W-1:0]           nsh;
   logic [mva_pkg::NSH_W-mva_pkg::SUM_W-1:0] n_hi;
   logic                                uw_neg, us_pos, sw_neg, too_big, emit;
   logic [mva_pkg::SUM_W:0]             tot;

   function automatic logic signed [mva_pkg::MUL_W-1:0] pick(
      mva_pkg::src_type s,
      logic signed [mva_pkg::DIFF_W-1:0] d [mva_pkg::NUM_DIFF],
      logic [mva_pkg::SCAL_W-1:0] m [mva_pkg::NUM_SCAL]);
      logic [mva_pkg::SCAL_W-1:0]        mv;
      logic signed [mva_pkg::MUL_W-1:0]  r;
      case (s[3:1])
         3'd0: mv = m[0];
         3'd1: mv = m[1];
         3'd2: mv = m[2];
         3'd3: mv = m[3];
         3'd4: mv = m[4];
         3'd5: mv = m[5];
         3'd6: mv = m[6];
         default: mv = m[7];
      endcase
      if (s[4]) begin
         r = s[0] ? {1'b0, mv[mva_pkg::SCAL_W-1:mva_pkg::LIMB_W]} :
                    {1'b0, mv[mva_pkg::LIMB_W-1:0]};
      end else begin
         case (s)
            mva_pkg::SRC_U0: r = mva_pkg::MUL_W'(d[0]);
            mva_pkg::SRC_U1: r = mva_pkg::MUL_W'(d[1]);
            mva_pkg::SRC_U2: r = mva_pkg::MUL_W'(d[2]);
            mva_pkg::SRC_W0: r = mva_pkg::MUL_W'(d[3]);
            mva_pkg::SRC_W1: r = mva_pkg::MUL_W'(d[4]);
            mva_pkg::SRC_W2: r = mva_pkg::MUL_W'(d[5]);
            mva_pkg::SRC_S0: r = mva_pkg::MUL_W'(d[6]);
            mva_pkg::SRC_S1: r = mva_pkg::MUL_W'(d[7]);
            mva_pkg::SRC_S2: r = mva_pkg::MUL_W'(d[8]);
            default:         r = '0;
         endcase
      end
      return r;
   endfunction

   assign step  = mva_pkg::step_desc(step_ff);
   assign issue = (state_ff == S_MAC1) || (state_ff == S_MAC2);
   assign opa   = pick(step.src_a, d_ff, mag_ff);
   assign opb   = pick(step.src_b, d_ff, mag_ff);

   mva_mac u_mac (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .step  (step),
      .opa   (opa),
      .opb   (opb),
      .acc   (mac_acc),
      .wr    (wr)
   );

   assign nsh     = {n_ff, {mva_pkg::DIV_SH{1'b0}}};
   assign n_hi    = nsh[mva_pkg::NSH_W-1:mva_pkg::SUM_W];
   assign too_big = mva_pkg::ROOT_W'(n_hi) >= r_ff;
   assign uw_neg  = scal_ff[mva_pkg::SC_UW][mva_pkg::SCAL_W-1];
   assign us_pos  = !scal_ff[mva_pkg::SC_US][mva_pkg::SCAL_W-1] && (|scal_ff[mva_pkg::SC_US]);
   assign sw_neg  = scal_ff[mva_pkg::SC_SW][mva_pkg::SCAL_W-1];

   always_comb begin
      cmd.start    = 1'b0;
      cmd.op       = mva_pkg::OP_SQRT;
      iter_operand = '0;
      unique case (state_ff)
         S_DECIDE: begin
            cmd.start    = (c2_ff != '0) && (uw_neg || us_pos || sw_neg);
            iter_operand = uw_neg ? mva_pkg::RAD_W'(c2_ff >> mva_pkg::HALF_SH) :
                                    mva_pkg::RAD_W'(c2_ff >> mva_pkg::QUART_SH);
         end
         S_WAIT2: begin
            cmd.start    = (wait_ff == 2'd2);
            iter_operand = {c2_ff, {mva_pkg::RAD_SH{1'b0}}};
         end
         S_CHECK: begin
            cmd.start    = !too_big;
            cmd.op       = mva_pkg::OP_DIV;
            iter_operand = {nsh[mva_pkg::SUM_W-1:0], {(mva_pkg::RAD_W-mva_pkg::SUM_W){1'b0}}};
         end
         default: ;
      endcase
   end

   mva_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .operand  (iter_operand),
      .rem_init (mva_pkg::ROOT_W'(n_hi)),
      .divisor  (r_ff),
      .done     (iter_done),
      .result   (iter_result)
   );

   assign tot     = {1'b0, sum_ff} + {1'b0, share_ff};
   assign sum_in  = (big_ff || tot[mva_pkg::SUM_W]) ? mva_pkg::SUM_MAX : tot[mva_pkg::SUM_W-1:0];
   assign clip_in = clip_ff || big_ff || tot[mva_pkg::SUM_W];
   assign emit    = (state_ff == S_ACCUM) && last_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      wait_in  = wait_ff;
      unique case (state_ff) inside
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_MAC1;
               step_in  = '0;
            end
         end
         S_MAC1: begin
            step_in = step_ff + 1'b1;
            if (step_ff == mva_pkg::STEP_W'(mva_pkg::PHASE1_LAST)) begin
               state_in = S_WAIT1;
               wait_in  = '0;
            end
         end
         S_WAIT1: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == 2'd2) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (c2_ff == '0) begin
               state_in = S_ACCUM;
            end else if (uw_neg || us_pos || sw_neg) begin
               state_in = S_AREA;
            end else begin
               state_in = S_MAC2;
               step_in  = mva_pkg::STEP_W'(mva_pkg::PHASE2_FIRST);
            end
         end
         S_MAC2: begin
            step_in = step_ff + 1'b1;
            if (step_ff == mva_pkg::STEP_W'(mva_pkg::PHASE2_LAST)) begin
               state_in = S_WAIT2;
               wait_in  = '0;
            end
         end
         S_WAIT2: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == 2'd2) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (iter_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = too_big ? S_ACCUM : S_DIV;
         end
         S_DIV, S_AREA: begin
            if (iter_done) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            if (!last_ff || emit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         wait_ff      <= '0;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         wait_ff  <= wait_in;
         if (state_ff == S_ACCUM && !last_ff) begin
            sum_ff  <= sum_in;
            clip_ff <= clip_in;
         end else if (emit) begin
            sum_ff  <= '0;
            clip_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == S_IDLE && req_chan.valid) begin
         last_ff <= req_chan.last_triangle;
         d_ff[0] <= mva_pkg::DIFF_W'(req_chan.first_x) - mva_pkg::DIFF_W'(req_chan.center_x);
         d_ff[1] <= mva_pkg::DIFF_W'(req_chan.first_y) - mva_pkg::DIFF_W'(req_chan.center_y);
         d_ff[2] <= mva_pkg::DIFF_W'(req_chan.first_z) - mva_pkg::DIFF_W'(req_chan.center_z);
         d_ff[3] <= mva_pkg::DIFF_W'(req_chan.second_x) - mva_pkg::DIFF_W'(req_chan.center_x);
         d_ff[4] <= mva_pkg::DIFF_W'(req_chan.second_y) - mva_pkg::DIFF_W'(req_chan.center_y);
         d_ff[5] <= mva_pkg::DIFF_W'(req_chan.second_z) - mva_pkg::DIFF_W'(req_chan.center_z);
         d_ff[6] <= mva_pkg::DIFF_W'(req_chan.second_x) - mva_pkg::DIFF_W'(req_chan.first_x);
         d_ff[7] <= mva_pkg::DIFF_W'(req_chan.second_y) - mva_pkg::DIFF_W'(req_chan.first_y);
         d_ff[8] <= mva_pkg::DIFF_W'(req_chan.second_z) - mva_pkg::DIFF_W'(req_chan.first_z);
      end
      if (wr.valid) begin
         if (wr.dst[3] == 1'b0) begin
            scal_ff[wr.dst[2:0]] <= mva_pkg::SCAL_W'(mac_acc);
         end else if (wr.dst == mva_pkg::DST_C2) begin
            c2_ff <= mac_acc;
         end else if (wr.dst == mva_pkg::DST_N) begin
            n_ff <= mac_acc;
         end
      end
      for (int i = 0; i < mva_pkg::NUM_SCAL; i++) begin
         mag_ff[i] <= scal_ff[i][mva_pkg::SCAL_W-1] ? -scal_ff[i] : scal_ff[i];
      end
      if (state_ff == S_ROOT && iter_done) begin
         r_ff <= iter_result;
      end
      if (state_ff == S_DECIDE) begin
         share_ff <= '0;
         big_ff   <= 1'b0;
      end else if (state_ff == S_CHECK) begin
         share_ff <= mva_pkg::SUM_MAX;
         big_ff   <= too_big;
      end else if ((state_ff == S_DIV || state_ff == S_AREA) && iter_done) begin
         share_ff <= iter_result[mva_pkg::SUM_W-1:0];
         big_ff   <= |iter_result[mva_pkg::ROOT_W-1:mva_pkg::SUM_W];
      end
      if (emit) begin
         rsp_area_ff <= sum_in;
         rsp_sat_ff  <= clip_in;
      end
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mixed_area = rsp_area_ff;
   assign rsp_chan.saturated  = rsp_sat_ff;

   `MVA_ASSERT_IMP(a_rsp_from_accum, $rose(rsp_valid_ff), $past(state_ff) == S_ACCUM, "response without accumulate")
   `MVA_ASSERT_NXT(a_clear_on_emit, emit, (sum_ff == '0) && !clip_ff && rsp_valid_ff, "fan not cleared on emit")
   `MVA_ASSERT_IMP(a_clip_holds_max, clip_ff, sum_ff == mva_pkg::SUM_MAX, "clip flag without full sum")
   `MVA_ASSERT_IMP(a_iter_done_state, iter_done, (state_ff == S_ROOT) || (state_ff == S_DIV) || (state_ff == S_AREA), "root/divide done outside wait")
endmodule

### verif/mva_area_checker.sv
`timescale 1ns / 1ps
// Mixed area checker: watches the triangle request and area response channels,
// predicts each fan sum exactly and compares it with the response. Depends on mva_pkg, mva_if.
module mva_area_checker (
   input  logic clock,
   input  logic reset,
   mva_req_if   req,
   mva_rsp_if   rsp,
   output int   error_count,
   output int   open_count
);
   import mva_pkg::*;

   typedef struct packed {
      logic [SUM_W-1:0] mixed_area;
      logic             saturated;
   } fan_area_t;

   fan_area_t        fan_queue[$];
   logic [SUM_W-1:0] fan_sum;
   logic             fan_clip;

   function automatic logic [255:0] root_floor(input logic [255:0] x);
      logic [255:0] res;
      logic [255:0] bitv;
      res  = '0;
      bitv = 256'd1 << 254;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] clamp64(input logic [255:0] v);
      return (v[255:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
   endfunction

   function automatic logic [63:0] triangle_area_share(
         input logic signed [COORD_W-1:0] pc[3], input logic signed [COORD_W-1:0] ac[3],
         input logic signed [COORD_W-1:0] bc[3]);
      logic signed [127:0] u[3], w[3], s[3];
      logic signed [127:0] cx, sq, uw, us, sw, uu, ww, nsum;
      logic [255:0]        c2, num, den;
      int                  j, k;
      for (int i = 0; i < 3; i++) begin
         u[i] = 128'(ac[i]) - 128'(pc[i]);
         w[i] = 128'(bc[i]) - 128'(pc[i]);
         s[i] = 128'(bc[i]) - 128'(ac[i]);
      end
      c2 = '0;
      for (int i = 0; i < 3; i++) begin
         j  = (i + 1) % 3;
         k  = (i + 2) % 3;
         cx = u[j] * w[k] - u[k] * w[j];
         sq = cx * cx;
         c2 = c2 + 256'(sq);
      end
      if (c2 == 0) return 64'd0;
      uw = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
      us = u[0] * s[0] + u[1] * s[1] + u[2] * s[2];
      sw = s[0] * w[0] + s[1] * w[1] + s[2] * w[2];
      if (uw < 0) return clamp64(root_floor(c2 >> HALF_SH));
      if (us > 0 || sw < 0) return clamp64(root_floor(c2 >> QUART_SH));
      uu   = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
      ww   = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
      nsum = sw * uu - us * ww;
      num  = 256'(nsum) << DIV_SH;
      den  = root_floor(c2 << RAD_SH);
      return clamp64(num / den);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      open_count  = 0;
   end

   always @(posedge clock) begin
      logic signed [COORD_W-1:0] pc[3], ac[3], bc[3];
      logic [63:0]               share;
      fan_area_t                 got, want;
      if (reset) begin
         fan_sum  = '0;
         fan_clip = 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            pc = '{req.center_x, req.center_y, req.center_z};
            ac = '{req.first_x, req.first_y, req.first_z};
            bc = '{req.second_x, req.second_y, req.second_z};
            share = triangle_area_share(pc, ac, bc);
            if (share > 64'(SUM_MAX) - 64'(fan_sum)) begin
               fan_sum  = SUM_MAX;
               fan_clip = 1'b1;
            end else begin
               fan_sum = fan_sum + share[SUM_W-1:0];
            end
            if (req.last_triangle) begin
               fan_queue.push_back('{fan_sum, fan_clip});
               fan_sum  = '0;
               fan_clip = 1'b0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.mixed_area, rsp.saturated};
            if (fan_queue.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(got.mixed_area), 64'd0);
            end else begin
               want = fan_queue.pop_front();
               if (got.mixed_area !== want.mixed_area)
                  report_mismatch("mixed_area", 64'(got.mixed_area), 64'(want.mixed_area));
               if (got.saturated !== want.saturated)
                  report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
            end
         end
      end
      open_count = fan_queue.size();
   end
endmodule

### verif/mixed_voronoi_area_accumulator_tb.sv
`timescale 1ns / 1ps
// Top of the mixed area accumulator bench: clock, reset, triangle stimulus and verdict.
// Depends on mva_pkg, mva_if, mva_area_checker and the accumulator RTL.
module mixed_voronoi_area_accumulator_tb;
   import mva_pkg::*;

   localparam int MAX_C = (1 << (COORD_W - 1)) - 1;
   localparam int MIN_C = -(1 << (COORD_W - 1));

   typedef struct {
      int p[3];
      int a[3];
      int b[3];
      bit last;
   } triangle_t;

   logic clock;
   logic reset;
   logic tail_quiet;
   logic hold_long;
   int   error_count;
   int   open_count;

   mva_req_if req_bus();
   mva_rsp_if rsp_bus();

   mixed_voronoi_area_accumulator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   mva_area_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .error_count (error_count),
      .open_count  (open_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_bus.ready <= 1'b0;
            repeat (4000) @(posedge clock);
            hold_long = 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic triangle_t make_tri(input int p[3], input int a[3], input int b[3],
                                          input bit last);
      triangle_t t;
      t.p = p;
      t.a = a;
      t.b = b;
      t.last = last;
      return t;
   endfunction

   function automatic int jitter(input int base, input int k);
      return base + int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k);
   endfunction

   function automatic triangle_t random_tri(input bit last);
      triangle_t t;
      int        k, mode, x, y, z;
      mode = $urandom_range(0, 9);
      k    = $urandom_range(1, COORD_W - 1);
      for (int i = 0; i < 3; i++) begin
         t.p[i] = int'($urandom);
         t.a[i] = (mode == 0) ? int'($urandom) : jitter(t.p[i], k);
         t.b[i] = (mode == 0) ? int'($urandom) : jitter(t.p[i], k);
      end
      if (mode == 1) begin
         case ($urandom_range(0, 2))
            0: t.b = t.a;
            1: t.a = t.p;
            default: for (int i = 0; i < 3; i++) t.b[i] = 2 * t.a[i] - t.p[i];
         endcase
      end else if (mode == 2) begin
         x = jitter(0, k - 1);
         y = jitter(0, k - 1);
         z = jitter(0, k - 1);
         t.a = '{t.p[0] + x, t.p[1] + y, t.p[2]};
         t.b = '{t.p[0] - y, t.p[1] + x, t.p[2] + z};
      end
      t.last = last;
      return t;
   endfunction

   task automatic send_triangle(input triangle_t t);
      if (!tail_quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.center_x      <= COORD_W'(t.p[0]);
      req_bus.center_y      <= COORD_W'(t.p[1]);
      req_bus.center_z      <= COORD_W'(t.p[2]);
      req_bus.first_x       <= COORD_W'(t.a[0]);
      req_bus.first_y       <= COORD_W'(t.a[1]);
      req_bus.first_z       <= COORD_W'(t.a[2]);
      req_bus.second_x      <= COORD_W'(t.b[0]);
      req_bus.second_y      <= COORD_W'(t.b[1]);
      req_bus.second_z      <= COORD_W'(t.b[2]);
      req_bus.last_triangle <= t.last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_random_fans(input int fans);
      int len;
      repeat (fans) begin
         len = $urandom_range(1, 8);
         for (int i = 1; i <= len; i++) send_triangle(random_tri(i == len));
      end
   endtask

   initial begin
      triangle_t t;
      reset         <= 1'b1;
      tail_quiet    = 1'b0;
      hold_long     = 1'b0;
      req_bus.valid <= 1'b0;
      req_bus.center_x <= '0; req_bus.center_y <= '0; req_bus.center_z <= '0;
      req_bus.first_x  <= '0; req_bus.first_y  <= '0; req_bus.first_z  <= '0;
      req_bus.second_x <= '0; req_bus.second_y <= '0; req_bus.second_z <= '0;
      req_bus.last_triangle <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes and degenerate cases
      send_triangle(make_tri('{MIN_C, MIN_C, MIN_C}, '{MIN_C, MIN_C, MIN_C},
                             '{MIN_C, MIN_C, MIN_C}, 1'b1));
      send_triangle(make_tri('{MAX_C, MAX_C, MAX_C}, '{MAX_C, MAX_C, MAX_C},
                             '{MIN_C, MIN_C, MIN_C}, 1'b1));
      send_triangle(make_tri('{0, 0, 0}, '{256, 0, 0}, '{768, 0, 0}, 1'b1));
      send_triangle(make_tri('{MIN_C, MIN_C, 0}, '{MAX_C, MIN_C, 0},
                             '{MIN_C, MAX_C, 0}, 1'b0));
      send_triangle(make_tri('{MAX_C, MAX_C, MAX_C}, '{MIN_C, MAX_C, MIN_C},
                             '{MAX_C, MIN_C, MIN_C}, 1'b1));
      // right angle, obtuse at centre, at first, at second, acute
      send_triangle(make_tri('{0, 0, 0}, '{256, 0, 0}, '{0, 512, 0}, 1'b0));
      send_triangle(make_tri('{0, 0, 0}, '{256, 0, 0}, '{-256, 64, 0}, 1'b0));
      send_triangle(make_tri('{0, 0, 0}, '{256, 0, 0}, '{512, 256, 0}, 1'b0));
      send_triangle(make_tri('{0, 0, 0}, '{512, 256, 0}, '{256, 0, 0}, 1'b0));
      send_triangle(make_tri('{0, 0, 0}, '{300, 20, 5}, '{140, 260, -7}, 1'b1));
      send_triangle(make_tri('{-1, -1, -1}, '{1, -1, 0}, '{-1, 1, 0}, 1'b1));
      send_triangle(make_tri('{MAX_C, 0, MIN_C}, '{MIN_C, 1, MAX_C},
                             '{0, MAX_C, 0}, 1'b1));

      send_random_fans(25);

      // receiver holds off while fans keep coming
      hold_long = 1'b1;
      send_random_fans(6);

      // pause until all fans are back
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (open_count == 0);
      send_random_fans(25);

      // one long fan of large obtuse triangles drives the sum into saturation
      for (int i = 1; i <= 1500; i++) begin
         t = make_tri('{jitter(0, 4), jitter(0, 4), jitter(0, 4)},
                      '{MAX_C - int'($urandom_range(0, 15)), MAX_C, MIN_C},
                      '{MIN_C, MAX_C - int'($urandom_range(0, 15)), MAX_C}, i == 1500);
         send_triangle(t);
      end

      send_random_fans(20);
      tail_quiet = 1'b1;
      send_random_fans(8);
      req_bus.valid <= 1'b0;
      @(posedge clock);

      wait (open_count == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0 && open_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
